@@ sv/bcs_pkg.sv @@
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared types, codes and constants of the Bezier curve sampler.
// ----------------------------------------------------------------------------
package bcs_pkg;

    localparam int MAX_POINTS_DEF  = 8;
    localparam int COORD_WIDTH_DEF = 32;

    localparam int FRAC_T = 30;          // fraction bits of t, u and weights
    localparam int T_W    = FRAC_T + 1;  // t and u lie in [0, 1.0]
    localparam int PT_W   = 32;          // control point coordinate
    localparam int SMP_W  = 6;           // sample count / sample number
    localparam int DEG_W  = 3;           // curve degree register
    localparam int CFG_W  = 6;           // config write data
    localparam int NUM_W  = 41;          // divider numerator
    localparam int DEN_W  = 10;          // divider denominator (10 * n)

    localparam logic [DEG_W-1:0] DEGREE_RESET = 3'd2;
    localparam logic [SMP_W-1:0] COUNT_RESET  = 6'd10;

    typedef enum logic {
        CFG_DEGREE = 1'b0,
        CFG_COUNT  = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_INIT,
        S_DIV,
        S_POW_INIT,
        S_POW,
        S_TERM_A,
        S_TERM_B,
        S_TERM_C,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic latch;
        logic div_init;
        logic pow_init;
        logic pow_step;
        logic term_init;
        logic term_a;
        logic term_b;
        logic term_c;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic pow_done;
        logic term_last;
        logic i_last;
        logic out_free;
    } t_sts;

    // binomial coefficients C(row, col), rows up to 12
    localparam logic [9:0] BINOM_TAB [0:12][0:12] = '{
        '{10'd1, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0},
        '{10'd1, 10'd1,  10'd0,  10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0},
        '{10'd1, 10'd2,  10'd1,  10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0},
        '{10'd1, 10'd3,  10'd3,  10'd1,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0},
        '{10'd1, 10'd4,  10'd6,  10'd4,   10'd1,   10'd0,   10'd0,   10'd0,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0},
        '{10'd1, 10'd5,  10'd10, 10'd10,  10'd5,   10'd1,   10'd0,   10'd0,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0},
        '{10'd1, 10'd6,  10'd15, 10'd20,  10'd15,  10'd6,   10'd1,   10'd0,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0},
        '{10'd1, 10'd7,  10'd21, 10'd35,  10'd35,  10'd21,  10'd7,   10'd1,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0},
        '{10'd1, 10'd8,  10'd28, 10'd56,  10'd70,  10'd56,  10'd28,  10'd8,   10'd1,
          10'd0, 10'd0,  10'd0,  10'd0},
        '{10'd1, 10'd9,  10'd36, 10'd84,  10'd126, 10'd126, 10'd84,  10'd36,  10'd9,
          10'd1, 10'd0,  10'd0,  10'd0},
        '{10'd1, 10'd10, 10'd45, 10'd120, 10'd210, 10'd252, 10'd210, 10'd120, 10'd45,
          10'd10, 10'd1, 10'd0,  10'd0},
        '{10'd1, 10'd11, 10'd55, 10'd165, 10'd330, 10'd462, 10'd462, 10'd330, 10'd165,
          10'd55, 10'd11, 10'd1, 10'd0},
        '{10'd1, 10'd12, 10'd66, 10'd220, 10'd495, 10'd792, 10'd924, 10'd792, 10'd495,
          10'd220, 10'd66, 10'd12, 10'd1}
    };

endpackage

@@ sv/bcs_ram.sv @@
// ----------------------------------------------------------------------------
// bcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/bcs_div.sv @@
// ----------------------------------------------------------------------------
// bcs_div
// Restoring divider, one quotient bit per cycle, for the sample parameter t.
// ----------------------------------------------------------------------------
module bcs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bcs_pkg::NUM_W-1:0]  i_num,
    input  logic [bcs_pkg::DEN_W-1:0]  i_den,
    output logic [bcs_pkg::T_W-1:0]    o_quot,
    output logic                       o_done
);
    import bcs_pkg::*;

    localparam int CNT_W = $clog2(T_W);

    logic [DEN_W-1:0] r_rem;
    logic [T_W-1:0]   r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {r_rem, r_q[T_W-1]};
    assign ge    = trial >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(T_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // upper numerator bits stay below the divisor, so the quotient fits T_W bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[NUM_W-1:T_W];
            r_q   <= i_num[T_W-1:0];
        end else if (r_busy) begin
            r_rem <= ge ? DEN_W'(trial - {1'b0, i_den}) : DEN_W'(trial);
            r_q   <= {r_q[T_W-2:0], ge};
        end
    end

    assign o_quot = r_q;
    assign o_done = !r_busy;

endmodule

@@ sv/bcs_dp.sv @@
// ----------------------------------------------------------------------------
// bcs_dp
// Datapath: config registers, t divider, point store, t/u powers, Bernstein terms,
// accumulators, rounding, saturation and the result register.
// ----------------------------------------------------------------------------
module bcs_dp #(
    parameter int MAX_POINTS  = bcs_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = bcs_pkg::COORD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bcs_pkg::t_cmd              i_cmd,
    output bcs_pkg::t_sts              o_sts,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [bcs_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic [2:0]                 i_point_index,
    input  logic signed [31:0]         i_point_x,
    input  logic signed [31:0]         i_point_y,
    input  logic signed [31:0]         i_point_z,
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic signed [31:0]         o_pos_x,
    output logic signed [31:0]         o_pos_y,
    output logic signed [31:0]         o_pos_z,
    output logic signed [31:0]         o_tan_x,
    output logic signed [31:0]         o_tan_y,
    output logic signed [31:0]         o_tan_z,
    output logic [bcs_pkg::SMP_W-1:0]  o_sample_number,
    output logic                       o_last
);
    import bcs_pkg::*;

    localparam int AW     = $clog2(MAX_POINTS);
    localparam int DW     = AW;
    localparam int KW     = $clog2(MAX_POINTS + 1);
    localparam int ACC_W  = 80;
    localparam int RND_W  = ACC_W - FRAC_T;
    localparam int TAN_W  = RND_W + DW + 1;
    localparam logic [T_W-1:0] ONE_T = T_W'(64'd1 << FRAC_T);
    localparam logic [ACC_W-1:0] HALF_ACC = ACC_W'(64'd1 << (FRAC_T - 1));
    localparam logic signed [TAN_W-1:0] SAT_HI =
        {{(TAN_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [TAN_W-1:0] SAT_LO =
        {{(TAN_W - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

    function automatic logic [T_W-1:0] mul_t(input logic [T_W-1:0] a,
                                             input logic [T_W-1:0] b);
        logic [2*T_W-1:0] p;
        p = a * b + (2*T_W)'(64'd1 << (FRAC_T - 1));
        return p[FRAC_T+T_W-1:FRAC_T];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [TAN_W-1:0] v);
        logic signed [TAN_W-1:0] r;
        if (v > SAT_HI) r = SAT_HI;
        else if (v < SAT_LO) r = SAT_LO;
        else r = v;
        return r[31:0];
    endfunction

    // config and per-run registers
    logic [DEG_W-1:0] r_degree;
    logic [SMP_W-1:0] r_count;
    logic [SMP_W-1:0] r_n;
    logic [DW-1:0]    r_d;
    logic [SMP_W-1:0] r_i;
    logic [KW-1:0]    r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= DEGREE_RESET;
            r_count  <= COUNT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_DEGREE) r_degree <= i_cfg_data[DEG_W-1:0];
            else                         r_count  <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_n <= (r_count == '0) ? SMP_W'(1) : r_count;
            r_d <= (32'(r_degree) > MAX_POINTS - 1) ? DW'(MAX_POINTS - 1) : DW'(r_degree);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
        end else if (i_cmd.latch) begin
            r_i <= '0;
        end else if (i_cmd.fin) begin
            r_i <= r_i + 1'b1;
        end
    end

    // t = (n + 8i) / (10n), rounded half up in Q1.30
    logic [DEN_W-1:0] den;
    logic [9:0]       n_plus;
    logic [8:0]       n_half;
    logic [NUM_W-1:0] num;
    logic [T_W-1:0]   quot;
    logic             div_done;

    assign den    = DEN_W'({r_n, 3'b000}) + DEN_W'({r_n, 1'b0});
    assign n_plus = 10'({r_i, 3'b000}) + 10'(r_n);
    assign n_half = 9'({r_n, 2'b00}) + 9'(r_n);
    assign num    = {1'b0, n_plus, {FRAC_T{1'b0}}} + NUM_W'(n_half);

    bcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_init),
        .i_num   (num),
        .i_den   (den),
        .o_quot  (quot),
        .o_done  (div_done)
    );

    // control point store
    logic [3*PT_W-1:0] rdata;

    bcs_ram #(.WIDTH(3 * PT_W), .DEPTH(MAX_POINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && (32'(i_point_index) < MAX_POINTS)),
        .i_waddr (AW'(i_point_index)),
        .i_wdata ({i_point_z, i_point_y, i_point_x}),
        .i_re    (i_cmd.term_a),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (rdata)
    );

    // powers of t and u, two shared rounding multipliers
    logic [T_W-1:0] r_tq, r_uq, r_tl, r_ul, r_tprev;
    logic [T_W-1:0] r_tp [MAX_POINTS];
    logic [T_W-1:0] r_up [MAX_POINTS];
    logic [T_W-1:0] r_pwp, r_pwd;
    logic [T_W-1:0] ma_a, ma_b, mb_a, mb_b, ma_y, mb_y;
    logic [DW-1:0]  k_lo, uidx;

    assign k_lo = r_k[DW-1:0];
    assign uidx = r_d - k_lo;

    always_comb begin
        if (i_cmd.term_a) begin
            ma_a = r_tp[k_lo];
            ma_b = r_up[uidx];
            mb_a = r_tprev;
            mb_b = r_up[uidx];
        end else begin
            ma_a = r_tl;
            ma_b = r_tq;
            mb_a = r_ul;
            mb_b = r_uq;
        end
    end

    assign ma_y = mul_t(ma_a, ma_b);
    assign mb_y = mul_t(mb_a, mb_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.pow_init) begin
            r_tq    <= quot;
            r_uq    <= ONE_T - quot;
            r_tl    <= ONE_T;
            r_ul    <= ONE_T;
            r_tp[0] <= ONE_T;
            r_up[0] <= ONE_T;
        end else if (i_cmd.pow_step) begin
            r_tp[k_lo] <= ma_y;
            r_up[k_lo] <= mb_y;
            r_tl       <= ma_y;
            r_ul       <= mb_y;
        end
        if (i_cmd.term_a) begin
            r_pwp   <= ma_y;   // t^k * u^(d-k)
            r_pwd   <= mb_y;   // t^(k-1) * u^(d-k), derivative weight of term k-1
            r_tprev <= r_tp[k_lo];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pow_init) begin
            r_k <= KW'(1);
        end else if (i_cmd.term_init) begin
            r_k <= '0;
        end else if (i_cmd.pow_step || i_cmd.term_c) begin
            r_k <= r_k + 1'b1;
        end
    end

    // per-coordinate products and accumulators
    logic signed [PT_W-1:0]  r_prev  [3];
    logic signed [63:0]      r_prodp [3];
    logic signed [64:0]      r_prodd [3];
    logic signed [ACC_W-1:0] r_accp  [3];
    logic signed [ACC_W-1:0] r_accd  [3];
    logic [9:0]              binp, bind_w;
    logic [3:0]              kd;

    assign kd     = (r_k == '0) ? 4'd0 : 4'(r_k) - 4'd1;
    assign binp   = BINOM_TAB[4'(r_d)][4'(r_k)];
    assign bind_w = BINOM_TAB[(r_d == '0) ? 4'd0 : 4'(r_d) - 4'd1][kd];

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.term_b) begin
                r_prodp[c] <= 64'($signed(rdata[c*PT_W +: PT_W]))
                              * 64'($signed({1'b0, r_pwp}));
                r_prodd[c] <= 65'(33'($signed(rdata[c*PT_W +: PT_W])) - 33'(r_prev[c]))
                              * 65'($signed({1'b0, r_pwd}));
                r_prev[c]  <= $signed(rdata[c*PT_W +: PT_W]);
            end
            if (i_cmd.term_init) begin
                r_accp[c] <= '0;
                r_accd[c] <= '0;
            end else if (i_cmd.term_c) begin
                r_accp[c] <= r_accp[c]
                             + ACC_W'(r_prodp[c]) * ACC_W'($signed({1'b0, binp}));
                if (r_k != '0) begin
                    r_accd[c] <= r_accd[c]
                                 + ACC_W'(r_prodd[c]) * ACC_W'($signed({1'b0, bind_w}));
                end
            end
        end
    end

    // rounding half up, derivative scaling, saturation
    logic signed [ACC_W-1:0] sp [3];
    logic signed [ACC_W-1:0] sd [3];
    logic signed [TAN_W-1:0] vpos [3];
    logic signed [TAN_W-1:0] vtan [3];
    logic [31:0]             res_p [3];
    logic [31:0]             res_d [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sp[c]    = r_accp[c] + $signed(HALF_ACC);
            sd[c]    = r_accd[c] + $signed(HALF_ACC);
            vpos[c]  = TAN_W'($signed(sp[c][ACC_W-1:FRAC_T]));
            vtan[c]  = TAN_W'($signed(sd[c][ACC_W-1:FRAC_T]))
                       * TAN_W'($signed({1'b0, r_d}));
            res_p[c] = sat32(vpos[c]);
            res_d[c] = sat32(vtan[c]);
        end
    end

    // result register
    logic r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            o_pos_x         <= res_p[0];
            o_pos_y         <= res_p[1];
            o_pos_z         <= res_p[2];
            o_tan_x         <= res_d[0];
            o_tan_y         <= res_d[1];
            o_tan_z         <= res_d[2];
            o_sample_number <= r_i;
            o_last          <= (r_i == r_n);
        end
    end

    assign o_valid         = r_valid;
    assign o_sts.div_done  = div_done;
    assign o_sts.pow_done  = r_k > KW'(r_d);
    assign o_sts.term_last = r_k == KW'(r_d);
    assign o_sts.i_last    = r_i == r_n;
    assign o_sts.out_free  = !r_valid || !i_stall;

endmodule

@@ sv/bcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// bcs_ctrl
// Sequencer: accepts requests, steps divider, powers, terms and result load.
// ----------------------------------------------------------------------------
module bcs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_op,
    output logic           o_stall,
    input  bcs_pkg::t_sts  i_sts,
    output bcs_pkg::t_cmd  o_cmd
);
    import bcs_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_op == OP_EVAL) begin
                        o_cmd.latch = 1'b1;
                        n_state     = S_DIV_INIT;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_POW_INIT;
            end
            S_POW_INIT: begin
                o_cmd.pow_init = 1'b1;
                n_state        = S_POW;
            end
            S_POW: begin
                if (i_sts.pow_done) begin
                    o_cmd.term_init = 1'b1;
                    n_state         = S_TERM_A;
                end else begin
                    o_cmd.pow_step = 1'b1;
                end
            end
            S_TERM_A: begin
                o_cmd.term_a = 1'b1;
                n_state      = S_TERM_B;
            end
            S_TERM_B: begin
                o_cmd.term_b = 1'b1;
                n_state      = S_TERM_C;
            end
            S_TERM_C: begin
                o_cmd.term_c = 1'b1;
                n_state      = i_sts.term_last ? S_FIN : S_TERM_A;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = i_sts.i_last ? S_IDLE : S_DIV_INIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/bezier_curve_sampler_unit.sv @@
// ----------------------------------------------------------------------------
// bezier_curve_sampler_unit
// Bezier curve sampler: stores 3-D control points, emits curve points and
// tangents at evenly spaced parameters, signed Q16.16, saturated.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): op 0 loads a control point into slot
//   point_index; op 1 starts an evaluation run of sample_count+1 results
//   (2 if sample_count is 0). o_stall stays high for the whole run.
//   Output channel (o_valid / i_stall): one request per sample, with
//   sample_number and last marking the final sample.
//   Config port: write curve_degree (index 0) or sample_count (index 1) while
//   the block is idle.
//   Sequence: each sample starts and runs the bit-serial divider that forms
//   t, then sets up and steps the powers of t and u, passes each control
//   point through the term multipliers in states TERM_A, TERM_B and TERM_C
//   and loads the result, which waits for a free output.
//   A stalled result waits in the output register while the next sample is
//   computed; the sequencer holds before loading that next result.
//   Reset clears the sequencer, the result valid and the config registers
//   (degree 2, 10 intervals); control points are undefined until loaded.
// ----------------------------------------------------------------------------
module bezier_curve_sampler_unit #(
    parameter int MAX_POINTS  = bcs_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = bcs_pkg::COORD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_op,
    input  logic [2:0]                 i_point_index,
    input  logic signed [31:0]         i_point_x,
    input  logic signed [31:0]         i_point_y,
    input  logic signed [31:0]         i_point_z,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [bcs_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [31:0]         o_pos_x,
    output logic signed [31:0]         o_pos_y,
    output logic signed [31:0]         o_pos_z,
    output logic signed [31:0]         o_tan_x,
    output logic signed [31:0]         o_tan_y,
    output logic signed [31:0]         o_tan_z,
    output logic [bcs_pkg::SMP_W-1:0]  o_sample_number,
    output logic                       o_last
);
    import bcs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bcs_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_point_index   (i_point_index),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_point_z       (i_point_z),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_pos_z         (o_pos_z),
        .o_tan_x         (o_tan_x),
        .o_tan_y         (o_tan_y),
        .o_tan_z         (o_tan_z),
        .o_sample_number (o_sample_number),
        .o_last          (o_last)
    );

endmodule

@@ sv/bcs_chk.sv @@
// ----------------------------------------------------------------------------
// bcs_chk
// Port-level checks of the Bezier curve sampler, bound to the top level.
// ----------------------------------------------------------------------------
module bcs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_op,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_pos_x,
    input logic [31:0] o_tan_x,
    input logic [5:0]  o_sample_number,
    input logic        o_last
);
    import bcs_pkg::*;

    // stalled request keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pos_x) && $stable(o_tan_x)
                               && $stable(o_sample_number) && $stable(o_last))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("not idle after reset");

    // a run has at least two samples
    a_last_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_sample_number != '0)
        else $error("last flag on first sample");

    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_op == OP_EVAL) |=> o_stall)
        else $error("evaluate request did not start a run");

    a_run_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_stall || o_valid)
        else $error("run ended before last sample");

endmodule

bind bezier_curve_sampler_unit bcs_chk u_bcs_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_op            (i_op),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_pos_x         (o_pos_x),
    .o_tan_x         (o_tan_x),
    .o_sample_number (o_sample_number),
    .o_last          (o_last)
);
